@@ rtl/fcs_pkg.sv @@
// Package: shared types and constants for the FASTA to color-space stream unit.
`timescale 1ns / 1ps

package fcs_pkg;

    localparam int CharWidth  = 8;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [CharWidth-1:0] CHAR_T      = 8'h54;
    localparam logic [CharWidth-1:0] CHAR_N      = 8'h4E;
    localparam logic [CharWidth-1:0] CHAR_A      = 8'h41;
    localparam logic [CharWidth-1:0] CHAR_C      = 8'h43;
    localparam logic [CharWidth-1:0] CHAR_G      = 8'h47;
    localparam logic [CharWidth-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CharWidth-1:0] CHAR_GT     = 8'h3E;
    localparam logic [CharWidth-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CharWidth-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CharWidth-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CharWidth-1:0] CHAR_LF     = 8'h0A;
    localparam logic [CharWidth-1:0] CHAR_VT     = 8'h0B;
    localparam logic [CharWidth-1:0] CHAR_FF     = 8'h0C;
    localparam logic [CharWidth-1:0] CHAR_CR     = 8'h0D;
    localparam logic [CharWidth-1:0] CHAR_LOW_A  = 8'h61;
    localparam logic [CharWidth-1:0] CHAR_LOW_Z  = 8'h7A;
    localparam logic [CharWidth-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic [2:0] {
        MODE_SEQ  = 3'b001,
        MODE_HDR  = 3'b010,
        MODE_HALT = 3'b100
    } mode_t;

    typedef enum logic [2:0] {
        PB_NONE = 3'd0,
        PB_A    = 3'd1,
        PB_C    = 3'd2,
        PB_G    = 3'd3,
        PB_T    = 3'd4,
        PB_N    = 3'd5,
        PB_BAD  = 3'd6
    } base_t;

    typedef struct packed {
        logic [CharWidth-1:0] out_char;
        logic                 bad_symbol;
        logic                 last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_out_t;

endpackage

@@ rtl/fcs_if.sv @@
// Interfaces: valid/ready channels for text bytes and color-space results.
`timescale 1ns / 1ps

interface fcs_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface fcs_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       bad_symbol;
    logic       last_of_run;

    modport source (output valid, output out_char, output bad_symbol,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_char, input bad_symbol,
                    input last_of_run, output ready);
endinterface

@@ rtl/fasta_to_color_space_stream_unit.sv @@
// Top level: FASTA text byte stream to color-space result stream.
//
//   channel | role   | payload
//   --------+--------+-------------------------------------------
//   text    | sink   | in_char[7:0]
//   color   | source | out_char[7:0], bad_symbol, last_of_run
//
// One text byte is taken per cycle; each is decoded in the same cycle against the
// mode and previous-base registers and its zero, one or two results enter a
// four-entry result FIFO, which drives color one result per cycle unless stalled.
// A header newline makes two results, so a byte after it may have to wait.
// text.ready drops while fewer than two FIFO entries would be free.
// Reset clears the mode (sequence), previous base (none) and the FIFO.
`timescale 1ns / 1ps

module fasta_to_color_space_stream_unit (
    input  logic        clk,
    input  logic        rst_n,
    fcs_text_if.sink    text,
    fcs_color_if.source color
);
    import fcs_pkg::*;

    step_out_t            step;
    result_t              head;
    logic                 accept;
    logic                 pop;
    logic                 not_empty;
    logic [QueueCntW-1:0] count;

    assign pop        = color.valid && color.ready;
    assign text.ready = (count <= QueueCntW'(QueueDepth - 2))
                     || ((count == QueueCntW'(QueueDepth - 1)) && pop);
    assign accept     = text.valid && text.ready;

    fcs_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_char (text.in_char),
        .step    (step)
    );

    fcs_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (accept ? step.count : 2'd0),
        .push_first  (step.first),
        .push_second (step.second),
        .pop         (pop),
        .head        (head),
        .not_empty   (not_empty),
        .count       (count)
    );

    assign color.valid       = not_empty;
    assign color.out_char    = head.out_char;
    assign color.bad_symbol  = head.bad_symbol;
    assign color.last_of_run = head.last_of_run;

    a_bad_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (color.valid && color.bad_symbol) |-> (color.last_of_run && color.out_char == '0))
        else $error("error result not final or not zero");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count <= QueueCntW'(QueueDepth))
        else $error("result queue overflow");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && color.bad_symbol) |=> !color.valid)
        else $error("result after error");

    a_pair_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step.count == 2'd2) |=> color.valid)
        else $error("two-result transaction not queued");

endmodule

@@ rtl/fcs_step.sv @@
// Step logic: mode and previous-base registers with per-byte result decode.
`timescale 1ns / 1ps

module fcs_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [fcs_pkg::CharWidth-1:0] in_char,
    output fcs_pkg::step_out_t          step
);
    import fcs_pkg::*;

    mode_t                mode_reg;
    mode_t                mode_next;
    base_t                prev_reg;
    base_t                prev_next;
    logic [CharWidth-1:0] upper;
    base_t                code;
    logic                 is_ws;
    logic [1:0]           color;

    function automatic result_t make_result(logic [CharWidth-1:0] ch, logic bad,
                                            logic last);
        result_t r;
        r.out_char    = ch;
        r.bad_symbol  = bad;
        r.last_of_run = last;
        return r;
    endfunction

    always_comb
    begin
        is_ws = (in_char == CHAR_SPACE) || (in_char == CHAR_TAB) || (in_char == CHAR_LF)
             || (in_char == CHAR_VT) || (in_char == CHAR_FF) || (in_char == CHAR_CR);
        upper = in_char;
        if (in_char >= CHAR_LOW_A && in_char <= CHAR_LOW_Z)
        begin
            upper = in_char - CASE_OFFSET;
        end
        unique case (upper)
            CHAR_A:  code = PB_A;
            CHAR_C:  code = PB_C;
            CHAR_G:  code = PB_G;
            CHAR_T:  code = PB_T;
            CHAR_N:  code = PB_N;
            default: code = PB_BAD;
        endcase
        color = 2'(prev_reg - PB_A) ^ 2'(code - PB_A);
    end

    always_comb
    begin
        mode_next   = mode_reg;
        prev_next   = prev_reg;
        step.count  = 2'd0;
        step.first  = make_result(in_char, 1'b0, 1'b1);
        step.second = make_result(CHAR_T, 1'b0, 1'b1);
        unique case (mode_reg)
            MODE_HALT:
            begin
                step.count = 2'd0;
            end
            MODE_HDR:
            begin
                if (in_char == CHAR_LF)
                begin
                    step.count             = 2'd2;
                    step.first.last_of_run = 1'b0;
                    mode_next              = MODE_SEQ;
                    prev_next              = PB_T;
                end
                else
                begin
                    step.count = 2'd1;
                end
            end
            MODE_SEQ:
            begin
                if (in_char == CHAR_GT)
                begin
                    step.count = 2'd1;
                    mode_next  = MODE_HDR;
                end
                else if (is_ws)
                begin
                    step.count = 2'd1;
                end
                else if (prev_reg == PB_NONE)
                begin
                    prev_next = code;
                end
                else if (prev_reg == PB_BAD || code == PB_BAD)
                begin
                    step.count = 2'd1;
                    step.first = make_result('0, 1'b1, 1'b1);
                    mode_next  = MODE_HALT;
                end
                else if (prev_reg == PB_N || code == PB_N)
                begin
                    step.count = 2'd1;
                    step.first = make_result(CHAR_DOT, 1'b0, 1'b1);
                    prev_next  = code;
                end
                else
                begin
                    step.count = 2'd1;
                    step.first = make_result(CHAR_ZERO | CharWidth'(color), 1'b0, 1'b1);
                    prev_next  = code;
                end
            end
            default:
            begin
                mode_next = MODE_SEQ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SEQ;
            prev_reg <= PB_NONE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            prev_reg <= prev_next;
        end
    end

endmodule

@@ rtl/fcs_result_queue.sv @@
// Result queue: register FIFO taking up to two results per cycle, one out.
`timescale 1ns / 1ps

module fcs_result_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    push_count,
    input  fcs_pkg::result_t              push_first,
    input  fcs_pkg::result_t              push_second,
    input  logic                          pop,
    output fcs_pkg::result_t              head,
    output logic                          not_empty,
    output logic [fcs_pkg::QueueCntW-1:0] count
);
    import fcs_pkg::*;

    result_t                entry_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wr_ptr_reg;
    logic [QueuePtrW-1:0]   wr_ptr_next;
    logic [QueuePtrW-1:0]   rd_ptr_reg;
    logic [QueuePtrW-1:0]   rd_ptr_next;
    logic [QueueCntW-1:0]   count_reg;
    logic [QueueCntW-1:0]   count_next;
    logic                   do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QueuePtrW'(push_count);
        rd_ptr_next = rd_ptr_reg + QueuePtrW'(do_pop);
        count_next  = count_reg + QueueCntW'(push_count) - QueueCntW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + QueuePtrW'(1)] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ verif/fasta_to_color_space_stream_unit_tb.sv @@
// Testbench: FASTA text bytes in, checked color-space results out, predicted per byte.
`timescale 1ns / 1ps

module fasta_to_color_space_stream_unit_tb;
    import fcs_pkg::*;

    typedef struct packed {
        logic [CharWidth-1:0] ch;
        logic                 typed;
        logic [1:0]           n;
        result_t              r0;
        result_t              r1;
    } text_row_t;

    localparam int DirectedRows  = 25;
    localparam int RandomEnd     = 1775;
    localparam int IdleEnd       = 1450;
    localparam int IdleWindow    = 250;
    localparam int PressureAt    = 700;
    localparam int HoldOffCycles = 60;
    localparam int DrainLimit    = 5000;
    localparam int SettleCycles  = 20;

    localparam text_row_t DirectedTable [DirectedRows] = '{
        '{8'hFF,      1'b1, 2'd0, '0, '0},
        '{CHAR_SPACE, 1'b0, 2'd0, '0, '0},
        '{CHAR_GT,    1'b0, 2'd0, '0, '0},
        '{8'h00,      1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, '0},
        '{8'hFF,      1'b1, 2'd1, '{8'hFF, 1'b0, 1'b1}, '0},
        '{CHAR_GT,    1'b0, 2'd0, '0, '0},
        '{8'h80,      1'b0, 2'd0, '0, '0},
        '{8'h7F,      1'b0, 2'd0, '0, '0},
        '{CHAR_LF,    1'b1, 2'd2, '{CHAR_LF, 1'b0, 1'b0}, '{CHAR_T, 1'b0, 1'b1}},
        '{CHAR_A,     1'b0, 2'd0, '0, '0},
        '{8'h63,      1'b0, 2'd0, '0, '0},
        '{CHAR_G,     1'b0, 2'd0, '0, '0},
        '{8'h74,      1'b0, 2'd0, '0, '0},
        '{CHAR_N,     1'b0, 2'd0, '0, '0},
        '{8'h61,      1'b0, 2'd0, '0, '0},
        '{CHAR_TAB,   1'b0, 2'd0, '0, '0},
        '{CHAR_VT,    1'b0, 2'd0, '0, '0},
        '{CHAR_FF,    1'b0, 2'd0, '0, '0},
        '{CHAR_CR,    1'b0, 2'd0, '0, '0},
        '{CHAR_LF,    1'b0, 2'd0, '0, '0},
        '{CHAR_T,     1'b0, 2'd0, '0, '0},
        '{8'h67,      1'b0, 2'd0, '0, '0},
        '{CHAR_GT,    1'b0, 2'd0, '0, '0},
        '{CHAR_LF,    1'b1, 2'd2, '{CHAR_LF, 1'b0, 1'b0}, '{CHAR_T, 1'b0, 1'b1}},
        '{8'h6E,      1'b0, 2'd0, '0, '0}
    };

    localparam logic [7:0] BaseChars [10] = '{
        CHAR_A, CHAR_C, CHAR_G, CHAR_T, CHAR_N, 8'h61, 8'h63, 8'h67, 8'h74, 8'h6E
    };
    localparam logic [7:0] BlankChars [6] = '{
        CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fcs_text_if  text_ch ();
    fcs_color_if color_ch ();

    fasta_to_color_space_stream_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .color (color_ch)
    );

    mode_t     pred_mode = MODE_SEQ;
    base_t     pred_prev = PB_NONE;
    result_t   pending_colors [$];
    text_row_t offered_rows [$];
    int        mismatches   = 0;
    int        items_sent   = 0;
    bit        hold_off_req = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
               c == CHAR_FF || c == CHAR_CR;
    endfunction

    function automatic base_t base_of(input logic [7:0] c);
        logic [7:0] u;
        u = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - CASE_OFFSET : c;
        case (u)
            CHAR_A:  return PB_A;
            CHAR_C:  return PB_C;
            CHAR_G:  return PB_G;
            CHAR_T:  return PB_T;
            CHAR_N:  return PB_N;
            default: return PB_BAD;
        endcase
    endfunction

    function automatic int encode_char(input logic [7:0] c, output result_t r0,
                                       output result_t r1);
        base_t      code;
        logic [1:0] a;
        logic [1:0] b;
        r0 = '0;
        r1 = '0;
        if (pred_mode == MODE_HALT)
            return 0;
        if (pred_mode == MODE_HDR)
        begin
            if (c == CHAR_LF)
            begin
                r0 = '{c, 1'b0, 1'b0};
                r1 = '{CHAR_T, 1'b0, 1'b1};
                pred_mode = MODE_SEQ;
                pred_prev = PB_T;
                return 2;
            end
            r0 = '{c, 1'b0, 1'b1};
            return 1;
        end
        if (c == CHAR_GT)
        begin
            r0 = '{c, 1'b0, 1'b1};
            pred_mode = MODE_HDR;
            return 1;
        end
        if (is_blank(c))
        begin
            r0 = '{c, 1'b0, 1'b1};
            return 1;
        end
        code = base_of(c);
        if (pred_prev == PB_NONE)
        begin
            pred_prev = code;
            return 0;
        end
        if (pred_prev >= PB_BAD || code == PB_BAD)
        begin
            r0 = '{8'h00, 1'b1, 1'b1};
            pred_mode = MODE_HALT;
            return 1;
        end
        if (pred_prev == PB_N || code == PB_N)
            r0 = '{CHAR_DOT, 1'b0, 1'b1};
        else
        begin
            a  = 2'(pred_prev - PB_A);
            b  = 2'(code - PB_A);
            r0 = '{CHAR_ZERO + 8'(a ^ b), 1'b0, 1'b1};
        end
        pred_prev = code;
        return 1;
    endfunction

    function automatic bit text_idle_on();
        return items_sent < IdleEnd && (items_sent / IdleWindow) % 3 != 1 && !hold_off_req;
    endfunction

    function automatic bit color_idle_on();
        return items_sent < IdleEnd && (items_sent / IdleWindow) % 3 != 0;
    endfunction

    task automatic send_row(input text_row_t row);
        if (text_idle_on() && $urandom_range(0, 5) == 0)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        offered_rows.push_back(row);
        text_ch.valid   <= 1'b1;
        text_ch.in_char <= row.ch;
        do @(posedge clk); while (!text_ch.ready);
        items_sent++;
        if (items_sent == PressureAt)
            hold_off_req = 1'b1;
    endtask

    task automatic send_char(input logic [7:0] c);
        text_row_t row;
        row    = '0;
        row.ch = c;
        send_row(row);
    endtask

    always @(posedge clk)
    begin : scoreboard
        text_row_t row;
        result_t   p0;
        result_t   p1;
        result_t   want;
        int        n;
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                row = offered_rows.pop_front();
                n   = encode_char(row.ch, p0, p1);
                if (row.typed)
                begin
                    n  = row.n;
                    p0 = row.r0;
                    p1 = row.r1;
                end
                if (n > 0)
                    pending_colors.push_back(p0);
                if (n > 1)
                    pending_colors.push_back(p1);
            end
            if (color_ch.valid && color_ch.ready)
            begin
                if (pending_colors.size() == 0)
                    report_mismatch($sformatf("unexpected transaction out_char=%h",
                                              color_ch.out_char));
                else
                begin
                    want = pending_colors.pop_front();
                    if (color_ch.out_char !== want.out_char)
                        report_mismatch($sformatf("out_char %h, want %h",
                                                  color_ch.out_char, want.out_char));
                    if (color_ch.bad_symbol !== want.bad_symbol)
                        report_mismatch($sformatf("bad_symbol %b, want %b",
                                                  color_ch.bad_symbol, want.bad_symbol));
                    if (color_ch.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %b, want %b",
                                                  color_ch.last_of_run, want.last_of_run));
                end
            end
        end
    end

    initial
    begin : color_drain
        color_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                color_ch.ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (color_idle_on() && $urandom_range(0, 7) == 0)
            begin
                color_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            color_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        text_row_t  row;
        logic [7:0] c;
        int         len;
        int         kind;
        int         guard;
        text_ch.valid   <= 1'b0;
        text_ch.in_char <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DirectedTable[i])
            send_row(DirectedTable[i]);

        while (items_sent < RandomEnd)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 3)
            begin
                send_char(CHAR_GT);
                len = $urandom_range(0, 10);
                repeat (len)
                begin
                    c = 8'($urandom_range(0, 255));
                    send_char(c == CHAR_LF ? c ^ 8'h80 : c);
                end
                if ($urandom_range(0, 9) != 0)
                    send_char(CHAR_LF);
            end
            else if (kind == 3)
                send_char(BlankChars[$urandom_range(0, 5)]);
            else
            begin
                len = $urandom_range(1, 30);
                repeat (len)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_char(BlankChars[$urandom_range(0, 5)]);
                    else
                        send_char(BaseChars[$urandom_range(0, 9)]);
                end
                send_char(CHAR_LF);
            end
        end

        send_char(CHAR_GT);
        send_char(CHAR_LF);
        send_char(CHAR_A);
        do c = 8'($urandom_range(0, 255));
        while (base_of(c) != PB_BAD || is_blank(c) || c == CHAR_GT);
        row       = '0;
        row.ch    = c;
        row.typed = 1'b1;
        row.n     = 2'd1;
        row.r0    = '{8'h00, 1'b1, 1'b1};
        send_row(row);
        repeat (6)
            send_char(8'($urandom_range(0, 255)));
        text_ch.valid <= 1'b0;

        guard = 0;
        @(posedge clk);
        while (pending_colors.size() != 0 && guard < DrainLimit)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SettleCycles) @(posedge clk);
        if (pending_colors.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_colors.size()));
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
